@@ src/grct_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package grct_pkg;

  localparam int MaxSide    = 32;
  localparam int MaxResults = 63;
  localparam int CoordW     = 24;
  localparam int SizeW      = 23;
  localparam int CountW     = 6;
  localparam int IdxW       = $clog2(MaxSide);
  localparam int TW         = 32;
  localparam int ResCntW    = $clog2(MaxResults + 1);
  // Dividend: a size of up to 23 bits shifted left by 16.
  localparam int NumW       = SizeW + 16;
  localparam int DivCntW    = $clog2(NumW + 1);
  localparam logic [TW-1:0] TOne = TW'(32'h0001_0000);
  localparam logic [TW-1:0] TMax = '1;

  typedef enum logic [2:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_CELL_WIDTH  = 3'd2,
    REG_CELL_HEIGHT = 3'd3,
    REG_COLUMNS     = 3'd4,
    REG_ROWS        = 3'd5
  } reg_index_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_WALK,
    ST_EMIT
  } state_e;

  // Which quantity the shared divider works on.
  typedef enum logic [1:0] {
    DIV_CELL_X,
    DIV_CELL_Y,
    DIV_DT,
    DIV_T
  } div_sel_e;

  typedef struct packed {
    logic     load;      // capture the ray
    logic     div_start; // start a division
    div_sel_e div_sel;
    logic     div_axis;  // 0 x, 1 y (for DIV_DT and DIV_T)
    logic     step;      // run one traversal step
    logic     emit;      // present the current cell
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic outside;   // start lies outside the grid
    logic finish;    // the next step would end the ray
  } ctrl_sts_t;

endpackage
`default_nettype wire

@@ src/grid_ray_cell_traversal.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o  start_x/y, end_x/y, segment_mode
// out       output     out_valid_o/out_ready_i  cell_x, cell_y, outside, last
// cfg       input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// A ray is taken only in idle. One radix-2 divider serves the two cell
// divisions and the four step divisions in turn, and the first cell is
// offered once all six are done; a start outside the grid gives its single
// result after the two cell divisions. Then one cell follows every cycle
// while the receiver takes them, up to 63. A held result stalls the walk,
// and the input is ready again once the last result is loaded.
// Reset sets origin 0, cell size 1.0 and a 32 by 32 grid.
module grid_ray_cell_traversal import grct_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [2:0]               cfg_index_i,
  input  wire logic [CoordW-1:0]        cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [CoordW-1:0] start_x_i,
  input  wire logic signed [CoordW-1:0] start_y_i,
  input  wire logic signed [CoordW-1:0] end_x_i,
  input  wire logic signed [CoordW-1:0] end_y_i,
  input  wire logic                     segment_mode_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [IdxW-1:0]               cell_x_o,
  output logic [IdxW-1:0]               cell_y_o,
  output logic                          outside_o,
  output logic                          last_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic [IdxW-1:0] cx, cy;
  logic [IdxW-1:0] cell_x_q, cell_y_q;

  assign cfg_ready_o = 1'b1;

  grct_datapath u_dp (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .start_x_i, .start_y_i, .end_x_i, .end_y_i, .segment_mode_i,
    .cmd_i(cmd), .sts_o(sts), .cell_x_o(cx), .cell_y_o(cy)
  );

  grct_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .outside_o, .last_o, .sts_i(sts), .cmd_o(cmd)
  );

  // Result cell register, loaded with each cell offered; cleared to 0 for an outside result.
  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      cell_x_q <= cx;
      cell_y_q <= cy;
    end else if (cmd.div_sel == DIV_DT && sts.outside && !out_valid_o) begin
      cell_x_q <= '0;
      cell_y_q <= '0;
    end
  end

  assign cell_x_o = cell_x_q;
  assign cell_y_o = cell_y_q;

endmodule
`default_nettype wire

@@ src/grct_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module grct_datapath import grct_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  input  wire logic [2:0]               cfg_index_i,
  input  wire logic [CoordW-1:0]        cfg_data_i,
  input  wire logic signed [CoordW-1:0] start_x_i,
  input  wire logic signed [CoordW-1:0] start_y_i,
  input  wire logic signed [CoordW-1:0] end_x_i,
  input  wire logic signed [CoordW-1:0] end_y_i,
  input  wire logic                     segment_mode_i,
  input  ctrl_cmd_t                     cmd_i,
  output ctrl_sts_t                     sts_o,
  output logic [IdxW-1:0]               cell_x_o,
  output logic [IdxW-1:0]               cell_y_o
);

  logic signed [CoordW-1:0] origin_x_q, origin_y_q;
  logic [SizeW-1:0]  cell_w_q, cell_h_q;
  logic [CountW-1:0] cols_q, rows_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      cell_w_q   <= SizeW'(256);
      cell_h_q   <= SizeW'(256);
      cols_q     <= CountW'(MaxSide);
      rows_q     <= CountW'(MaxSide);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ORIGIN_X:    origin_x_q <= cfg_data_i;
        REG_ORIGIN_Y:    origin_y_q <= cfg_data_i;
        REG_CELL_WIDTH:  cell_w_q   <= cfg_data_i[SizeW-1:0];
        REG_CELL_HEIGHT: cell_h_q   <= cfg_data_i[SizeW-1:0];
        REG_COLUMNS:     cols_q     <= cfg_data_i[CountW-1:0];
        REG_ROWS:        rows_q     <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes and counts.
  logic [SizeW-1:0]  wid, hei;
  logic [CountW-1:0] ncol, nrow;
  assign wid  = (cell_w_q == '0) ? SizeW'(1) : cell_w_q;
  assign hei  = (cell_h_q == '0) ? SizeW'(1) : cell_h_q;
  assign ncol = (cols_q == '0) ? CountW'(1) :
                (cols_q > CountW'(MaxSide)) ? CountW'(MaxSide) : cols_q;
  assign nrow = (rows_q == '0) ? CountW'(1) :
                (rows_q > CountW'(MaxSide)) ? CountW'(MaxSide) : rows_q;

  // Ray registers: u = start - origin, v = end - start (25 bit signed).
  logic signed [CoordW:0] ux_q, uy_q, vx_q, vy_q;
  logic seg_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ux_q  <= (CoordW+1)'(start_x_i) - (CoordW+1)'(origin_x_q);
      uy_q  <= (CoordW+1)'(start_y_i) - (CoordW+1)'(origin_y_q);
      vx_q  <= (CoordW+1)'(end_x_i) - (CoordW+1)'(start_x_i);
      vy_q  <= (CoordW+1)'(end_y_i) - (CoordW+1)'(start_y_i);
      seg_q <= segment_mode_i;
    end
  end

  logic [CoordW-1:0] avx, avy;
  assign avx = vx_q[CoordW] ? CoordW'(-vx_q) : vx_q[CoordW-1:0];
  assign avy = vy_q[CoordW] ? CoordW'(-vy_q) : vy_q[CoordW-1:0];

  // Shared restoring divider, one quotient bit a cycle.
  logic [NumW-1:0]    num_sel, quo_q;
  logic [CoordW-1:0]  den_sel, den_q;
  logic [CoordW:0]    rem_q;
  logic [DivCntW-1:0] dcnt_q;
  logic               dbusy_q;
  logic [SizeW-1:0]   rx_q, ry_q;
  logic [SizeW-1:0]   dsz;

  always_comb begin
    num_sel = '0;
    den_sel = '0;
    dsz     = cmd_i.div_axis ? hei : wid;
    case (cmd_i.div_sel)
      DIV_CELL_X: begin
        num_sel = NumW'(ux_q[CoordW-1:0]);
        den_sel = CoordW'(wid);
      end
      DIV_CELL_Y: begin
        num_sel = NumW'(uy_q[CoordW-1:0]);
        den_sel = CoordW'(hei);
      end
      DIV_DT: begin
        num_sel = {dsz, 16'h0000};
        den_sel = cmd_i.div_axis ? avy : avx;
      end
      DIV_T: begin
        if (!cmd_i.div_axis)
          num_sel = {(vx_q[CoordW] ? rx_q : wid - rx_q), 16'h0000};
        else
          num_sel = {(vy_q[CoordW] ? ry_q : hei - ry_q), 16'h0000};
        den_sel = cmd_i.div_axis ? avy : avx;
      end
      default: ;
    endcase
  end

  logic [CoordW:0] rem_sh, rem_sub;
  assign rem_sh  = {rem_q[CoordW-1:0], quo_q[NumW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= DivCntW'(NumW);
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q - 1'b1;
      if (dcnt_q == DivCntW'(1)) dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q <= num_sel;
      den_q <= den_sel;
      rem_q <= '0;
    end else if (dbusy_q) begin
      if (!rem_sub[CoordW]) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  logic div_done;
  assign div_done = dbusy_q && (dcnt_q == DivCntW'(1));

  // Final quotient bit and saturation, as seen in the finishing cycle.
  logic [NumW-1:0] quo_fin;
  logic [CoordW:0] rem_fin;
  logic [TW-1:0]   quo_sat;
  assign quo_fin = {quo_q[NumW-2:0], ~rem_sub[CoordW]};
  assign rem_fin = rem_sub[CoordW] ? rem_sh : rem_sub;
  assign quo_sat = (den_q == '0 || quo_fin[NumW-1:TW] != '0) ? TMax : quo_fin[TW-1:0];

  // Traversal state.
  logic signed [CountW:0] px_q, py_q;
  logic [TW-1:0] tx_q, ty_q, dtx_q, dty_q;
  logic outside_q;
  logic signed [CountW:0] px_nx, py_nx, stopx, stopy;
  logic [TW-1:0] tx_nx, ty_nx;
  logic [TW:0]   sumx, sumy;
  logic fin, dx, dy;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      outside_q <= 1'b0;
    end else if (div_done) begin
      case (cmd_i.div_sel)
        DIV_CELL_X: begin
          rx_q <= rem_fin[SizeW-1:0];
          if (ux_q[CoordW] || quo_fin >= NumW'(ncol)) outside_q <= 1'b1;
          px_q <= (CountW+1)'(quo_fin[CountW-1:0]);
        end
        DIV_CELL_Y: begin
          ry_q <= rem_fin[SizeW-1:0];
          if (uy_q[CoordW] || quo_fin >= NumW'(nrow)) outside_q <= 1'b1;
          py_q <= (CountW+1)'(quo_fin[CountW-1:0]);
        end
        DIV_DT: begin
          if (cmd_i.div_axis) dty_q <= quo_sat;
          else                dtx_q <= quo_sat;
        end
        DIV_T: begin
          if (cmd_i.div_axis) ty_q <= quo_sat;
          else                tx_q <= quo_sat;
        end
        default: ;
      endcase
    end else if (cmd_i.step) begin
      px_q <= px_nx;
      py_q <= py_nx;
      tx_q <= tx_nx;
      ty_q <= ty_nx;
    end
  end

  // One step of the DDA.
  assign stopx = vx_q[CoordW] ? '1 : (CountW+1)'(ncol);
  assign stopy = vy_q[CoordW] ? '1 : (CountW+1)'(nrow);
  assign sumx  = {1'b0, tx_q} + {1'b0, dtx_q};
  assign sumy  = {1'b0, ty_q} + {1'b0, dty_q};

  always_comb begin
    px_nx = px_q;
    py_nx = py_q;
    tx_nx = tx_q;
    ty_nx = ty_q;
    fin   = 1'b0;
    dx    = tx_q <= ty_q;
    dy    = ty_q <= tx_q;
    if (seg_q && tx_q > TOne && ty_q > TOne) begin
      fin = 1'b1;
    end else begin
      if (dx) begin
        px_nx = vx_q[CoordW] ? px_q - 1'b1 : px_q + 1'b1;
        if (px_nx == stopx) fin = 1'b1;
        else tx_nx = sumx[TW] ? TMax : sumx[TW-1:0];
      end
      if (!fin && dy) begin
        py_nx = vy_q[CoordW] ? py_q - 1'b1 : py_q + 1'b1;
        if (py_nx == stopy) fin = 1'b1;
        else ty_nx = sumy[TW] ? TMax : sumy[TW-1:0];
      end
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.outside  = outside_q;
  assign sts_o.finish   = fin;
  assign cell_x_o = px_q[IdxW-1:0];
  assign cell_y_o = py_q[IdxW-1:0];

endmodule
`default_nettype wire

@@ src/grct_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module grct_ctrl import grct_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic      outside_o,
  output logic      last_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  div_sel_e sel_q, sel_d;
  logic axis_q, axis_d;
  logic [ResCntW-1:0] n_q, n_d;
  logic out_valid_q, out_valid_d, last_q, last_d, outside_q, outside_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= DIV_CELL_X;
      axis_q      <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      outside_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      axis_q      <= axis_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      outside_q   <= outside_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    axis_d      = axis_q;
    n_d         = n_q;
    out_valid_d = out_valid_q;
    last_d      = last_q;
    outside_d   = outside_q;
    cmd_o       = '0;
    cmd_o.div_sel  = sel_q;
    cmd_o.div_axis = axis_q;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          sel_d      = DIV_CELL_X;
          axis_d     = 1'b0;
          n_d        = '0;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (sts_i.div_done) begin
          state_d = ST_SETUP;
          case (sel_q)
            DIV_CELL_X: sel_d = DIV_CELL_Y;
            DIV_CELL_Y: sel_d = DIV_DT;
            DIV_DT: begin
              if (axis_q) begin
                sel_d  = DIV_T;
                axis_d = 1'b0;
              end else begin
                axis_d = 1'b1;
              end
            end
            DIV_T: begin
              if (axis_q) state_d = ST_EMIT;
              else axis_d = 1'b1;
            end
            default: ;
          endcase
          // After both cell divisions the outside flag is known.
          if (sel_q == DIV_CELL_Y) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_WALK: begin
        // Result register is free, or being taken; present the current cell.
        if (!out_valid_q || out_ready_i) begin
          n_d         = n_q + 1'b1;
          out_valid_d = 1'b1;
          outside_d   = 1'b0;
          last_d      = sts_i.finish || (n_q + 1'b1 >= ResCntW'(MaxResults));
          cmd_o.emit  = 1'b1;
          if (last_d) state_d = ST_IDLE;
          else cmd_o.step = 1'b1;
        end
      end
      ST_EMIT: begin
        // Reached after the cell divisions, or after the t divisions.
        if (sel_q == DIV_DT && sts_i.outside) begin
          if (!out_valid_q) begin
            out_valid_d = 1'b1;
            outside_d   = 1'b1;
            last_d      = 1'b1;
            state_d     = ST_IDLE;
          end
        end else if (sel_q == DIV_DT) begin
          state_d = ST_SETUP;
        end else begin
          state_d = ST_WALK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (out_valid_q && out_ready_i && !(cmd_o.emit || (outside_d && !outside_q))) begin
      out_valid_d = 1'b0;
    end
    if (out_valid_q && out_ready_i && state_q == ST_IDLE) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;
  assign outside_o   = outside_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire
